[sv/lsu_pkg.sv]
// load/store unit package: sequencer states and instruction bit positions
package lsu_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_LOAD,
    ST_LTAIL,
    ST_STORE,
    ST_PRE,
    ST_DONE
  } state_t;

  // instruction word bit positions
  localparam int unsigned BIT_IDX  = 10;  // pre/post index form
  localparam int unsigned BIT_PRE  = 11;  // pre-index when set
  localparam int unsigned BIT_NOWB = 21;  // register offset form when set
  localparam int unsigned BIT_LOAD = 22;
  localparam int unsigned BIT_UOFF = 24;  // unsigned scaled offset
  localparam int unsigned BIT_XFER = 29;  // transfer vs load literal
  localparam int unsigned BIT_WIDE = 30;  // 64-bit access

endpackage

[sv/lsu_ram.sv]
// generic single-port ram with registered read
module lsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/load_store_unit.sv]
// load/store unit: reduced single data transfer over an internal byte memory
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_ready  | operation, instruction, registers, preload
//   out_    | output    | out_valid/out_ready| load, writeback, address, fault
//
// one byte of memory is touched per cycle through the single ram port.
// preload: ST_PRE; load: ST_CALC, ST_CHECK, ST_LOAD per byte, ST_LTAIL; store: ST_CALC,
// ST_CHECK, ST_STORE per byte (size 4 or 8); a faulting transfer: ST_CALC, ST_CHECK.
// after reset a clearing pass zeroes the memory, in_ready low.
// in_ready is high only when idle; the result holds until out_ready takes it.
module load_store_unit #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_instruction,
  input  logic [15:0] in_pc,
  input  logic [63:0] in_base_value,
  input  logic [63:0] in_index_value,
  input  logic [63:0] in_store_value,
  input  logic [15:0] in_preload_address,
  input  logic [7:0]  in_preload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_target_register,
  output logic [63:0] out_load_value,
  output logic        out_load_valid,
  output logic [4:0]  out_base_register,
  output logic [63:0] out_new_base_value,
  output logic        out_base_write,
  output logic [63:0] out_access_address,
  output logic        out_fault
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM_END = 64'(MEM_BYTES);
  localparam logic [63:0] LIMIT8  = 64'(MEM_BYTES - 8);
  localparam logic [63:0] LIMIT4  = 64'(MEM_BYTES - 4);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

  lsu_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [2:0]    rd_idx_r, rd_idx_nxt;

  logic [31:0] instr_r, instr_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] index_r, index_nxt;
  logic [63:0] store_r, store_nxt;
  logic [7:0]  pre_byte_r, pre_byte_nxt;
  logic [4:0]  tgt_r, tgt_nxt;
  logic [63:0] lval_r, lval_nxt;
  logic        lvalid_r, lvalid_nxt;
  logic [4:0]  breg_r, breg_nxt;
  logic [63:0] nbase_r, nbase_nxt;
  logic        bwrite_r, bwrite_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic        fault_r, fault_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic        is_wide, is_xfer, is_load, is_index;
  logic [63:0] opnd_a, opnd_b, sum;
  logic        xfer_ok, pre_ok, last_byte;

  lsu_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // decode of the held instruction
  assign is_wide  = instr_r[lsu_pkg::BIT_WIDE];
  assign is_xfer  = instr_r[lsu_pkg::BIT_XFER];
  assign is_load  = is_xfer ? instr_r[lsu_pkg::BIT_LOAD] : 1'b1;
  assign is_index = !instr_r[lsu_pkg::BIT_NOWB] && instr_r[lsu_pkg::BIT_IDX];

  // the shared adder: the writeback value and every transfer address but post-index come from here
  always_comb begin
    opnd_a = is_xfer ? base_r : {48'd0, pc_r};
    if (!is_xfer) begin
      opnd_b = {{43{instr_r[23]}}, instr_r[23:5], 2'b00};
    end else if (instr_r[lsu_pkg::BIT_UOFF]) begin
      opnd_b = is_wide ? {49'd0, instr_r[21:10], 3'b000} : {50'd0, instr_r[21:10], 2'b00};
    end else if (is_index) begin
      opnd_b = {{55{instr_r[20]}}, instr_r[20:12]};
    end else begin
      opnd_b = index_r;
    end
  end

  assign sum       = opnd_a + opnd_b;
  assign xfer_ok   = addr_r <= (is_wide ? LIMIT8 : LIMIT4);
  assign pre_ok    = addr_r < MEM_END;
  assign last_byte = cnt_r == (is_wide ? 3'd7 : 3'd3);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lsu_pkg::ST_CLEAR: if (clr_r == CLR_LAST) state_nxt = lsu_pkg::ST_IDLE;
      lsu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_operation ? lsu_pkg::ST_PRE : lsu_pkg::ST_CALC;
        end
      end
      lsu_pkg::ST_CALC: state_nxt = lsu_pkg::ST_CHECK;
      lsu_pkg::ST_CHECK: begin
        if (!xfer_ok) begin
          state_nxt = lsu_pkg::ST_DONE;
        end else begin
          state_nxt = is_load ? lsu_pkg::ST_LOAD : lsu_pkg::ST_STORE;
        end
      end
      lsu_pkg::ST_LOAD:  if (last_byte) state_nxt = lsu_pkg::ST_LTAIL;
      lsu_pkg::ST_LTAIL: state_nxt = lsu_pkg::ST_DONE;
      lsu_pkg::ST_STORE: if (last_byte) state_nxt = lsu_pkg::ST_DONE;
      lsu_pkg::ST_PRE:   state_nxt = lsu_pkg::ST_DONE;
      lsu_pkg::ST_DONE:  if (out_ready) state_nxt = lsu_pkg::ST_IDLE;
      default:           state_nxt = lsu_pkg::ST_CLEAR;
    endcase
  end

  // handshakes, ram port and byte counters
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = addr_r[AW-1:0] + AW'(cnt_r);
    ram_wdata   = store_r[{cnt_r, 3'b000} +: 8];
    clr_nxt     = clr_r;
    cnt_nxt     = cnt_r;
    rd_pend_nxt = 1'b0;
    rd_idx_nxt  = cnt_r;
    case (state_r)
      lsu_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = 8'd0;
        clr_nxt   = clr_r + AW'(1);
      end
      lsu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = 3'd0;
      end
      lsu_pkg::ST_LOAD: begin
        rd_pend_nxt = 1'b1;
        cnt_nxt     = cnt_r + 3'd1;
      end
      lsu_pkg::ST_STORE: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
      end
      lsu_pkg::ST_PRE: begin
        ram_we    = pre_ok;
        ram_addr  = addr_r[AW-1:0];
        ram_wdata = pre_byte_r;
      end
      lsu_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    instr_nxt    = instr_r;
    pc_nxt       = pc_r;
    base_nxt     = base_r;
    index_nxt    = index_r;
    store_nxt    = store_r;
    pre_byte_nxt = pre_byte_r;
    tgt_nxt      = tgt_r;
    lval_nxt     = lval_r;
    lvalid_nxt   = lvalid_r;
    breg_nxt     = breg_r;
    nbase_nxt    = nbase_r;
    bwrite_nxt   = bwrite_r;
    addr_nxt     = addr_r;
    fault_nxt    = fault_r;
    case (state_r)
      lsu_pkg::ST_IDLE: begin
        if (in_valid) begin
          instr_nxt    = in_instruction;
          pc_nxt       = in_pc;
          base_nxt     = in_base_value;
          index_nxt    = in_index_value;
          store_nxt    = in_store_value;
          pre_byte_nxt = in_preload_byte;
          tgt_nxt      = in_operation ? 5'd0 : in_instruction[4:0];
          lval_nxt     = 64'd0;
          lvalid_nxt   = 1'b0;
          breg_nxt     = 5'd0;
          nbase_nxt    = 64'd0;
          bwrite_nxt   = 1'b0;
          addr_nxt     = in_operation ? {48'd0, in_preload_address} : 64'd0;
          fault_nxt    = 1'b0;
        end
      end
      lsu_pkg::ST_CALC: begin
        addr_nxt = sum;
        if (is_xfer) begin
          breg_nxt = instr_r[9:5];
          if (!instr_r[lsu_pkg::BIT_UOFF] && is_index) begin
            nbase_nxt  = sum;
            bwrite_nxt = 1'b1;
            // post-index uses the unmodified base
            if (!instr_r[lsu_pkg::BIT_PRE]) addr_nxt = base_r;
          end
        end
      end
      lsu_pkg::ST_CHECK: begin
        if (!xfer_ok) begin
          fault_nxt  = 1'b1;
          nbase_nxt  = 64'd0;
          bwrite_nxt = 1'b0;
        end
      end
      lsu_pkg::ST_LTAIL: lvalid_nxt = 1'b1;
      lsu_pkg::ST_PRE:   fault_nxt  = !pre_ok;
      default: ;
    endcase
    // read data lands in the cycle after its address, little-endian by byte index
    if (rd_pend_r) begin
      lval_nxt[{rd_idx_r, 3'b000} +: 8] = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lsu_pkg::ST_CLEAR;
      clr_r     <= '0;
      cnt_r     <= 3'd0;
      rd_pend_r <= 1'b0;
      rd_idx_r  <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    instr_r    <= instr_nxt;
    pc_r       <= pc_nxt;
    base_r     <= base_nxt;
    index_r    <= index_nxt;
    store_r    <= store_nxt;
    pre_byte_r <= pre_byte_nxt;
    tgt_r      <= tgt_nxt;
    lval_r     <= lval_nxt;
    lvalid_r   <= lvalid_nxt;
    breg_r     <= breg_nxt;
    nbase_r    <= nbase_nxt;
    bwrite_r   <= bwrite_nxt;
    addr_r     <= addr_nxt;
    fault_r    <= fault_nxt;
  end

  assign out_target_register = tgt_r;
  assign out_load_value      = lval_r;
  assign out_load_valid      = lvalid_r;
  assign out_base_register   = breg_r;
  assign out_new_base_value  = nbase_r;
  assign out_base_write      = bwrite_r;
  assign out_access_address  = addr_r;
  assign out_fault           = fault_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> !out_load_valid && !out_base_write)
    else $error("faulting word carries a load or writeback");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accepting a word");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lsu_pkg::ST_CLEAR |-> !in_ready && !out_valid)
    else $error("handshake active during memory clear");

endmodule

[tb/load_store_unit_tb.sv]
// testbench for load_store_unit: scoreboard with byte memory model, directed and random words
module load_store_unit_tb;

  localparam int MEM_BYTES = 65536;
  localparam logic OP_XFER    = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  typedef enum int {
    MODE_UOFF,
    MODE_PRE,
    MODE_POST,
    MODE_REG,
    MODE_REG_ALT,
    MODE_LIT
  } xfer_mode_t;

  typedef struct packed {
    logic        op;
    logic [31:0] instr;
    logic [15:0] pc;
    logic [63:0] base;
    logic [63:0] index;
    logic [63:0] store;
    logic [15:0] pl_addr;
    logic [7:0]  pl_byte;
  } lsu_word_t;

  typedef struct packed {
    logic [4:0]  rt;
    logic [63:0] ldata;
    logic        lvalid;
    logic [4:0]  rn;
    logic [63:0] nbase;
    logic        bwrite;
    logic [63:0] addr;
    logic        fault;
  } lsu_result_t;

  class lsu_scoreboard_t;
    bit [7:0] mem [MEM_BYTES];
    lsu_result_t pending_q[$];
    int errors, n_checked, n_preload, n_load, n_store, n_fault;

    function lsu_result_t predict(lsu_word_t w);
      lsu_result_t r;
      logic [63:0] sz, s9, off;
      bit is_load;
      int idx;
      r = '0;
      if (w.op == OP_PRELOAD) begin
        n_preload++;
        r.addr = {48'd0, w.pl_addr};
        if (int'(w.pl_addr) < MEM_BYTES) mem[w.pl_addr] = w.pl_byte;
        else r.fault = 1'b1;
        return r;
      end
      sz = w.instr[lsu_pkg::BIT_WIDE] ? 64'd8 : 64'd4;
      is_load = 1'b1;
      r.rt = w.instr[4:0];
      if (w.instr[lsu_pkg::BIT_XFER]) begin
        r.rn = w.instr[9:5];
        is_load = w.instr[lsu_pkg::BIT_LOAD];
        if (w.instr[lsu_pkg::BIT_UOFF]) begin
          r.addr = w.base + {52'd0, w.instr[21:10]} * sz;
        end else if (!w.instr[lsu_pkg::BIT_NOWB] && w.instr[lsu_pkg::BIT_IDX]) begin
          s9 = {{55{w.instr[20]}}, w.instr[20:12]};
          r.nbase = w.base + s9;
          r.bwrite = 1'b1;
          r.addr = w.instr[lsu_pkg::BIT_PRE] ? r.nbase : w.base;
        end else begin
          r.addr = w.base + w.index;
        end
      end else begin
        off = {{43{w.instr[23]}}, w.instr[23:5], 2'b00};
        r.addr = {48'd0, w.pc} + off;
      end
      // whole access must lie inside memory, else nothing happens
      if (r.addr > 64'(MEM_BYTES) - sz) begin
        n_fault++;
        r.fault = 1'b1;
        r.nbase = '0;
        r.bwrite = 1'b0;
      end else begin
        idx = int'(r.addr[31:0]);
        if (is_load) begin
          n_load++;
          for (int i = 0; i < int'(sz); i++) r.ldata[8*i +: 8] = mem[idx + i];
          r.lvalid = 1'b1;
        end else begin
          n_store++;
          for (int i = 0; i < int'(sz); i++) mem[idx + i] = w.store[8*i +: 8];
        end
      end
      return r;
    endfunction

    function void note_word(lsu_word_t w);
      pending_q.push_back(predict(w));
    endfunction

    function void mismatch(string what, logic [63:0] e, logic [63:0] a);
      errors++;
      if (errors <= 10)
        $display("mismatch on result %0d, %s: expected %h got %h", n_checked, what, e, a);
    endfunction

    function void compare(string what, logic [63:0] e, logic [63:0] a);
      if (e !== a) mismatch(what, e, a);
    endfunction

    function void check_word(lsu_result_t a);
      lsu_result_t e;
      if (pending_q.size() == 0) begin
        mismatch("result with nothing pending, address", '0, a.addr);
        return;
      end
      e = pending_q.pop_front();
      compare("target_register", 64'(e.rt), 64'(a.rt));
      compare("load_value", e.ldata, a.ldata);
      compare("load_valid", 64'(e.lvalid), 64'(a.lvalid));
      compare("base_register", 64'(e.rn), 64'(a.rn));
      compare("new_base_value", e.nbase, a.nbase);
      compare("base_write", 64'(e.bwrite), 64'(a.bwrite));
      compare("access_address", e.addr, a.addr);
      compare("fault", 64'(e.fault), 64'(a.fault));
      n_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lsu_word_t   cur_word = '0;
  lsu_result_t out_word;

  logic        in_operation;
  logic [31:0] in_instruction;
  logic [15:0] in_pc;
  logic [63:0] in_base_value;
  logic [63:0] in_index_value;
  logic [63:0] in_store_value;
  logic [15:0] in_preload_address;
  logic [7:0]  in_preload_byte;
  logic [4:0]  out_target_register;
  logic [63:0] out_load_value;
  logic        out_load_valid;
  logic [4:0]  out_base_register;
  logic [63:0] out_new_base_value;
  logic        out_base_write;
  logic [63:0] out_access_address;
  logic        out_fault;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  lsu_scoreboard_t sb;

  assign in_operation       = cur_word.op;
  assign in_instruction     = cur_word.instr;
  assign in_pc              = cur_word.pc;
  assign in_base_value      = cur_word.base;
  assign in_index_value     = cur_word.index;
  assign in_store_value     = cur_word.store;
  assign in_preload_address = cur_word.pl_addr;
  assign in_preload_byte    = cur_word.pl_byte;

  assign out_word = {out_target_register, out_load_value, out_load_valid, out_base_register,
                     out_new_base_value, out_base_write, out_access_address, out_fault};

  load_store_unit #(.MEM_BYTES(MEM_BYTES)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_instruction     (in_instruction),
    .in_pc              (in_pc),
    .in_base_value      (in_base_value),
    .in_index_value     (in_index_value),
    .in_store_value     (in_store_value),
    .in_preload_address (in_preload_address),
    .in_preload_byte    (in_preload_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target_register(out_target_register),
    .out_load_value     (out_load_value),
    .out_load_valid     (out_load_valid),
    .out_base_register  (out_base_register),
    .out_new_base_value (out_new_base_value),
    .out_base_write     (out_base_write),
    .out_access_address (out_access_address),
    .out_fault          (out_fault)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_word);
    if (rst_n && in_valid && in_ready) sb.note_word(cur_word);
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(4 * 600000);
    $display("timeout waiting for the block");
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] mk_instr(logic [31:0] fill, xfer_mode_t mode, bit wide,
                                           bit ld, logic [18:0] imm);
    logic [31:0] v;
    v = fill;
    v[lsu_pkg::BIT_WIDE] = wide;
    if (mode == MODE_LIT) begin
      v[lsu_pkg::BIT_XFER] = 1'b0;
      v[23:5] = imm;
    end else begin
      v[lsu_pkg::BIT_XFER] = 1'b1;
      v[lsu_pkg::BIT_LOAD] = ld;
      case (mode)
        MODE_UOFF: begin
          v[lsu_pkg::BIT_UOFF] = 1'b1;
          v[21:10] = imm[11:0];
        end
        MODE_PRE, MODE_POST: begin
          v[lsu_pkg::BIT_UOFF] = 1'b0;
          v[lsu_pkg::BIT_NOWB] = 1'b0;
          v[lsu_pkg::BIT_IDX] = 1'b1;
          v[lsu_pkg::BIT_PRE] = (mode == MODE_PRE);
          v[20:12] = imm[8:0];
        end
        MODE_REG: begin
          v[lsu_pkg::BIT_UOFF] = 1'b0;
          v[lsu_pkg::BIT_NOWB] = 1'b1;
        end
        default: begin
          // register offset reached through bit21 and bit10 both clear
          v[lsu_pkg::BIT_UOFF] = 1'b0;
          v[lsu_pkg::BIT_NOWB] = 1'b0;
          v[lsu_pkg::BIT_IDX] = 1'b0;
        end
      endcase
    end
    return v;
  endfunction

  function automatic lsu_word_t xfer_word(logic [31:0] instr, logic [63:0] base,
                                          logic [63:0] index, logic [63:0] store,
                                          logic [15:0] pc);
    lsu_word_t w;
    w = '0;
    w.op = OP_XFER;
    w.instr = instr;
    w.base = base;
    w.index = index;
    w.store = store;
    w.pc = pc;
    return w;
  endfunction

  function automatic lsu_word_t preload_word(logic [15:0] a, logic [7:0] b);
    lsu_word_t w;
    w = '0;
    w.op = OP_PRELOAD;
    w.pl_addr = a;
    w.pl_byte = b;
    return w;
  endfunction

  // mostly low bytes and the top of memory, so loads see earlier writes
  function automatic logic [63:0] pick_address(int sz);
    int p;
    p = $urandom_range(99);
    if (p < 70) return 64'($urandom_range(255));
    if (p < 88) return 64'($urandom_range(MEM_BYTES - sz, MEM_BYTES - sz - 63));
    if (p < 96) return 64'(MEM_BYTES - sz + $urandom_range(8, 1));
    return {$urandom, $urandom};
  endfunction

  function automatic lsu_word_t random_word();
    lsu_word_t w;
    xfer_mode_t mode;
    bit wide;
    logic [63:0] tgt, sz, s9;
    logic [18:0] imm;
    longint k;
    int pick;
    w.op = OP_XFER;
    w.instr = $urandom;
    w.pc = 16'($urandom);
    w.base = {$urandom, $urandom};
    w.index = {$urandom, $urandom};
    w.store = {$urandom, $urandom};
    w.pl_addr = 16'($urandom);
    w.pl_byte = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) return w;
    if (pick < 25) begin
      w.op = OP_PRELOAD;
      tgt = pick_address(1);
      w.pl_addr = tgt[15:0];
      return w;
    end
    mode = xfer_mode_t'($urandom_range(5));
    wide = 1'($urandom_range(1));
    sz = wide ? 64'd8 : 64'd4;
    tgt = pick_address(int'(sz));
    imm = 19'($urandom);
    case (mode)
      MODE_UOFF: begin
        imm = ($urandom_range(3) == 0) ? 19'($urandom_range(4095)) : 19'($urandom_range(15));
        w.base = tgt - {52'd0, imm[11:0]} * sz;
      end
      MODE_PRE: begin
        s9 = {{55{imm[8]}}, imm[8:0]};
        w.base = tgt - s9;
      end
      MODE_POST: w.base = tgt;
      MODE_REG, MODE_REG_ALT: begin
        if ($urandom_range(1)) w.index = 64'($urandom_range(255));
        w.base = tgt - w.index;
      end
      default: begin
        if (tgt < 64'(MEM_BYTES)) begin
          k = (longint'(tgt) - longint'(w.pc)) / 4;
          imm = k[18:0];
        end
      end
    endcase
    w.instr = mk_instr(w.instr, mode, wide, 1'($urandom_range(1)), imm);
    return w;
  endfunction

  task automatic send_word(input lsu_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    cur_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [31:0] f;
    f = {22'd0, 5'd7, 5'd3};
    // load from cleared memory
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b1, 1'b1, 19'd0), 64'd0, 64'd0, 64'd0,
                        16'd0));
    send_word(preload_word(16'h0000, 8'h11));
    send_word(preload_word(16'h0003, 8'h44));
    send_word(preload_word(16'h0007, 8'h88));
    send_word(preload_word(16'hFFFF, 8'hFF));
    // byte order, then 32-bit zero extension
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b1, 1'b1, 19'd0), 64'd0, 64'd0, 64'd0,
                        16'd0));
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b0, 1'b1, 19'd1), 64'd0, 64'd0, 64'd0,
                        16'd0));
    // largest scaled offset
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b1, 1'b0, 19'd4095), 64'h40, 64'd0, '1,
                        16'd0));
    // pre-index with most negative offset reads the stored word back
    send_word(xfer_word(mk_instr(f, MODE_PRE, 1'b0, 1'b1, 19'h100), 64'd33080, 64'd0, 64'd0,
                        16'd0));
    send_word(xfer_word(mk_instr(f, MODE_POST, 1'b0, 1'b0, 19'h0FF), 64'h80, 64'd0,
                        64'h0123456789ABCDEF, 16'd0));
    // register offset with address wrap
    send_word(xfer_word(mk_instr(f, MODE_REG, 1'b1, 1'b1, 19'd0), 64'hFFFF_FFFF_FFFF_FFF0,
                        64'h90, 64'd0, 16'd0));
    send_word(xfer_word(mk_instr(f, MODE_REG_ALT, 1'b0, 1'b1, 19'd0), 64'h40, 64'h40, 64'd0,
                        16'd0));
    // literal forward, backward, wrap below zero, beyond the top
    send_word(xfer_word(mk_instr(f, MODE_LIT, 1'b1, 1'b1, 19'd4), 64'd0, 64'd0, 64'd0,
                        16'h0100));
    send_word(xfer_word(mk_instr(f, MODE_LIT, 1'b0, 1'b1, 19'h7FFFF), 64'd0, 64'd0, 64'd0,
                        16'h0100));
    send_word(xfer_word(mk_instr(f, MODE_LIT, 1'b0, 1'b1, 19'h7FFFF), 64'd0, 64'd0, 64'd0,
                        16'h0000));
    send_word(xfer_word(mk_instr(f, MODE_LIT, 1'b1, 1'b1, 19'h3FFFF), 64'd0, 64'd0, 64'd0,
                        16'hFFFF));
    // last fitting and first faulting access of each size
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b1, 1'b1, 19'd0), 64'd65528, 64'd0, 64'd0,
                        16'd0));
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b1, 1'b1, 19'd0), 64'd65529, 64'd0, 64'd0,
                        16'd0));
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b0, 1'b1, 19'd0), 64'd65532, 64'd0, 64'd0,
                        16'd0));
    send_word(xfer_word(mk_instr(f, MODE_UOFF, 1'b0, 1'b0, 19'd0), 64'd65533, 64'd0, '1,
                        16'd0));
    // faulting pre-index must drop its writeback
    send_word(xfer_word(mk_instr(f, MODE_PRE, 1'b1, 1'b1, 19'd8), 64'hFFFF, 64'd0, 64'd0,
                        16'd0));
    send_word(xfer_word(mk_instr(f, MODE_REG, 1'b1, 1'b0, 19'd0), '1, 64'd0, '1, 16'd0));
    send_word(xfer_word(32'hFFFF_FFFF, 64'd0, 64'd0, 64'd0, 16'd0));
    send_word(xfer_word(32'h0000_0000, 64'd0, 64'd0, 64'd0, 16'd0));
  endtask

  task automatic run_random(int count, int idle, int stall);
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_word(random_word());
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(325, 0, 0);
    run_random(325, 51, 0);
    run_random(325, 0, 51);
    run_random(325, 6, 6);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("checked %0d results: %0d preloads, %0d loads, %0d stores, %0d faults",
             sb.n_checked, sb.n_preload, sb.n_load, sb.n_store, sb.n_fault);
    $display("flow control: free running, sender gaps, receiver stalls, both; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[load_store_unit.f]
sv/lsu_pkg.sv
sv/lsu_ram.sv
sv/load_store_unit.sv
tb/load_store_unit_tb.sv
